FILE: hw/rtl/psa_pkg.sv
// shared constants and types for the point splat accumulator
package psa_pkg;

    localparam int IMAGE_WIDTH_DEF  = 320;
    localparam int IMAGE_HEIGHT_DEF = 240;

    localparam int OP_W     = 2;
    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 13;
    localparam int WEIGHT_W = 14;
    localparam int RX_W     = 9;
    localparam int RY_W     = 8;
    localparam int BYTE_W   = 8;
    localparam int ACC_W    = 16;
    localparam int TAP_W    = 12;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_CLEAR = 2'd0;
    localparam op_t OP_SPLAT = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_BG_RED   = 2'd0;
    localparam reg_idx_t REG_BG_GREEN = 2'd1;
    localparam reg_idx_t REG_BG_BLUE  = 2'd2;

    localparam logic [COLOR_W-1:0] BG_RED_RST   = 13'd102;
    localparam logic [COLOR_W-1:0] BG_GREEN_RST = 13'd0;
    localparam logic [COLOR_W-1:0] BG_BLUE_RST  = 13'd225;

    localparam logic [TAP_W-1:0] TAP_CENTRE = 12'd3482;
    localparam logic [TAP_W-1:0] TAP_SIDE   = 12'd1229;

endpackage

FILE: hw/rtl/psa_if.sv
// command and pixel channel interfaces of the point splat accumulator
interface psa_cmd_if;
    import psa_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [COLOR_W-1:0]         color_red;
    logic [COLOR_W-1:0]         color_green;
    logic [COLOR_W-1:0]         color_blue;
    logic [WEIGHT_W-1:0]        splat_weight;
    logic [RX_W-1:0]            read_x;
    logic [RY_W-1:0]            read_y;

    modport source (
        output valid, operation, point_x, point_y, color_red, color_green,
               color_blue, splat_weight, read_x, read_y,
        input  ready
    );

    modport sink (
        input  valid, operation, point_x, point_y, color_red, color_green,
               color_blue, splat_weight, read_x, read_y,
        output ready
    );
endinterface

interface psa_pix_if;
    import psa_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_red;
    logic [BYTE_W-1:0] pixel_green;
    logic [BYTE_W-1:0] pixel_blue;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue,
        input  ready
    );

    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

FILE: hw/rtl/point_splat_accumulator.sv
// point splat accumulator top level: image memory, shared multiplier and sequencer
// The block holds an IMAGE_WIDTH x IMAGE_HEIGHT image of three 16-bit Q4.12
// accumulators in one single-port-write, single-port-read memory and takes one
// item at a time; cmd.ready is high only while it is idle. A clear writes the
// background colour into one pixel a cycle; the image holds no meaning until the
// first clear. A splat runs nine steps of the one shared 27x14 multiplier (colour
// times weight for each channel, then times the centre and side taps), then the
// five taps as read-modify-write accesses pipelined through the memory, one tap a
// cycle, skipping taps outside the image. A read fetches the pixel from memory,
// then waits for the pixel channel; the result sits in an output register, and a
// read outside the image returns zeros.
// Background registers lie at byte addresses 0, 4 and 8 of the APB port.
module point_splat_accumulator #(
    parameter int IMAGE_WIDTH  = psa_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = psa_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psa_pkg::PADDR_W-1:0]   paddr,
    input  logic [psa_pkg::PDATA_W-1:0]   pwdata,
    output logic [psa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    psa_cmd_if.sink                       cmd,
    psa_pix_if.source                     pix
);
    import psa_pkg::*;

    localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int X_W    = $clog2(IMAGE_WIDTH);
    localparam int Y_W    = $clog2(IMAGE_HEIGHT);
    localparam int PIX_W  = 3 * ACC_W;
    localparam int CW_W   = COLOR_W + WEIGHT_W;
    localparam int PROD_W = CW_W + WEIGHT_W;
    localparam int HALF_W = PROD_W - 23;

    localparam logic signed [13:0] WIDTH_S  = 14'(IMAGE_WIDTH);
    localparam logic signed [13:0] HEIGHT_S = 14'(IMAGE_HEIGHT);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_TAP   = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;

    localparam logic [3:0] MSTEP_LAST = 4'd8;
    localparam logic [2:0] TAP_LAST   = 3'd5;

    function automatic logic [BYTE_W-1:0] to_byte(input logic [ACC_W-1:0] acc);
        logic [23:0] v;
        v = {acc, 8'd0} - 24'(acc);
        to_byte = (|v[23:20]) ? 8'hFF : v[19:12];
    endfunction

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic [3:0]               mstep_reg;
    logic [2:0]               tap_reg;
    logic                     pend_valid_reg;
    logic                     pix_valid_reg;
    logic [COLOR_W-1:0]       bg_red_reg;
    logic [COLOR_W-1:0]       bg_green_reg;
    logic [COLOR_W-1:0]       bg_blue_reg;

    logic signed [12:0]       xc_reg;
    logic signed [12:0]       yc_reg;
    logic [COLOR_W-1:0]       col_reg [3];
    logic [WEIGHT_W-1:0]      w_reg;
    logic [CW_W-1:0]          cw_reg [3];
    logic [HALF_W-1:0]        hc_reg [3];
    logic [HALF_W-1:0]        hs_reg [3];
    logic [ADDR_W-1:0]        pend_addr_reg;
    logic                     pend_centre_reg;
    logic                     oor_reg;
    logic [PIX_W-1:0]         rd_reg;
    logic [BYTE_W-1:0]        pix_red_reg;
    logic [BYTE_W-1:0]        pix_green_reg;
    logic [BYTE_W-1:0]        pix_blue_reg;

    logic [PIX_W-1:0]         mem [DEPTH];

    logic                     accept;
    logic signed [16:0]       px_sum;
    logic signed [16:0]       py_sum;
    logic                     cmd_in_range;
    logic [ADDR_W-1:0]        cmd_addr;
    logic [CW_W-1:0]          mul_a;
    logic [WEIGHT_W-1:0]      mul_b;
    logic [PROD_W-1:0]        mul_prod;
    logic signed [13:0]       dx;
    logic signed [13:0]       dy;
    logic signed [13:0]       tap_x;
    logic signed [13:0]       tap_y;
    logic                     tap_ok;
    logic [ADDR_W-1:0]        tap_addr;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [PIX_W-1:0]         wr_data;
    logic [PIX_W-1:0]         sat_data;
    logic [HALF_W:0]          tap_add [3];
    logic [HALF_W:0]          acc_sum [3];
    logic                     out_free;

    assign pready    = 1'b1;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !pix_valid_reg || pix.ready;

    assign pix.valid       = pix_valid_reg;
    assign pix.pixel_red   = pix_red_reg;
    assign pix.pixel_green = pix_green_reg;
    assign pix.pixel_blue  = pix_blue_reg;

    // config read back
    always_comb
    begin
        case (paddr[3:2])
            REG_BG_RED:   prdata = PDATA_W'(bg_red_reg);
            REG_BG_GREEN: prdata = PDATA_W'(bg_green_reg);
            REG_BG_BLUE:  prdata = PDATA_W'(bg_blue_reg);
            default:      prdata = '0;
        endcase
    end

    // splat centre rounded to whole pixels
    assign px_sum = {cmd.point_x[COORD_W-1], cmd.point_x} + 17'sd8;
    assign py_sum = {cmd.point_y[COORD_W-1], cmd.point_y} + 17'sd8;

    assign cmd_in_range = (11'(cmd.read_x) < 11'(IMAGE_WIDTH))
                       && (11'(cmd.read_y) < 11'(IMAGE_HEIGHT));
    assign cmd_addr = ADDR_W'(cmd.read_y) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(cmd.read_x);

    // shared multiplier operand select
    always_comb
    begin
        case (mstep_reg)
            4'd0:    begin mul_a = CW_W'(col_reg[0]); mul_b = w_reg; end
            4'd1:    begin mul_a = CW_W'(col_reg[1]); mul_b = w_reg; end
            4'd2:    begin mul_a = CW_W'(col_reg[2]); mul_b = w_reg; end
            4'd3:    begin mul_a = cw_reg[0]; mul_b = WEIGHT_W'(TAP_CENTRE); end
            4'd4:    begin mul_a = cw_reg[1]; mul_b = WEIGHT_W'(TAP_CENTRE); end
            4'd5:    begin mul_a = cw_reg[2]; mul_b = WEIGHT_W'(TAP_CENTRE); end
            4'd6:    begin mul_a = cw_reg[0]; mul_b = WEIGHT_W'(TAP_SIDE); end
            4'd7:    begin mul_a = cw_reg[1]; mul_b = WEIGHT_W'(TAP_SIDE); end
            4'd8:    begin mul_a = cw_reg[2]; mul_b = WEIGHT_W'(TAP_SIDE); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // tap offsets: centre, right, left, below, above
    always_comb
    begin
        case (tap_reg)
            3'd0:    begin dx = 14'sd0;  dy = 14'sd0;  end
            3'd1:    begin dx = 14'sd1;  dy = 14'sd0;  end
            3'd2:    begin dx = -14'sd1; dy = 14'sd0;  end
            3'd3:    begin dx = 14'sd0;  dy = 14'sd1;  end
            3'd4:    begin dx = 14'sd0;  dy = -14'sd1; end
            default: begin dx = 14'sd0;  dy = 14'sd0;  end
        endcase
    end

    assign tap_x  = {xc_reg[12], xc_reg} + dx;
    assign tap_y  = {yc_reg[12], yc_reg} + dy;
    assign tap_ok = (state_reg == ST_TAP) && (tap_reg < TAP_LAST)
                 && (tap_x >= 14'sd0) && (tap_x < WIDTH_S)
                 && (tap_y >= 14'sd0) && (tap_y < HEIGHT_S);
    assign tap_addr = ADDR_W'(tap_y[Y_W-1:0]) * ADDR_W'(IMAGE_WIDTH)
                    + ADDR_W'(tap_x[X_W-1:0]);

    // rounded contribution added with saturation
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            tap_add[c] = (HALF_W + 1)'(({1'b0, pend_centre_reg ? hc_reg[c] : hs_reg[c]}
                                        + (HALF_W + 1)'(1)) >> 1);
            acc_sum[c] = (HALF_W + 1)'(rd_reg[c*ACC_W +: ACC_W]) + tap_add[c];
            sat_data[c*ACC_W +: ACC_W] = (|acc_sum[c][HALF_W:ACC_W])
                                       ? {ACC_W{1'b1}} : acc_sum[c][ACC_W-1:0];
        end
    end

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = tap_addr;
        if (accept && (cmd.operation == OP_READ) && cmd_in_range)
        begin
            rd_en = 1'b1;
            rd_addr = cmd_addr;
        end
        else if (tap_ok)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = sat_data;
        if (state_reg == ST_CLEAR)
        begin
            wr_en = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = {ACC_W'(bg_blue_reg), ACC_W'(bg_green_reg), ACC_W'(bg_red_reg)};
        end
        else if ((state_reg == ST_TAP) && pend_valid_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_SPLAT: state_next = ST_MUL;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                if (mstep_reg == MSTEP_LAST)
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (tap_reg == TAP_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clr_addr_reg   <= '0;
            mstep_reg      <= '0;
            tap_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pix_valid_reg  <= 1'b0;
            bg_red_reg     <= BG_RED_RST;
            bg_green_reg   <= BG_GREEN_RST;
            bg_blue_reg    <= BG_BLUE_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    REG_BG_RED:   bg_red_reg   <= pwdata[COLOR_W-1:0];
                    REG_BG_GREEN: bg_green_reg <= pwdata[COLOR_W-1:0];
                    REG_BG_BLUE:  bg_blue_reg  <= pwdata[COLOR_W-1:0];
                    default:      ;
                endcase
            end

            if (state_reg == ST_IDLE)
            begin
                clr_addr_reg <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end

            if (state_reg == ST_MUL)
            begin
                mstep_reg <= mstep_reg + 4'd1;
            end
            else
            begin
                mstep_reg <= '0;
            end

            if (state_reg == ST_TAP)
            begin
                tap_reg        <= tap_reg + 3'd1;
                pend_valid_reg <= tap_ok;
            end
            else
            begin
                tap_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end

            if ((state_reg == ST_READ) && out_free)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xc_reg     <= px_sum[16:4];
            yc_reg     <= py_sum[16:4];
            col_reg[0] <= cmd.color_red;
            col_reg[1] <= cmd.color_green;
            col_reg[2] <= cmd.color_blue;
            w_reg      <= cmd.splat_weight;
            oor_reg    <= !cmd_in_range;
        end

        if (state_reg == ST_MUL)
        begin
            case (mstep_reg)
                4'd0:    cw_reg[0] <= mul_prod[CW_W-1:0];
                4'd1:    cw_reg[1] <= mul_prod[CW_W-1:0];
                4'd2:    cw_reg[2] <= mul_prod[CW_W-1:0];
                4'd3:    hc_reg[0] <= mul_prod[PROD_W-1:23];
                4'd4:    hc_reg[1] <= mul_prod[PROD_W-1:23];
                4'd5:    hc_reg[2] <= mul_prod[PROD_W-1:23];
                4'd6:    hs_reg[0] <= mul_prod[PROD_W-1:23];
                4'd7:    hs_reg[1] <= mul_prod[PROD_W-1:23];
                4'd8:    hs_reg[2] <= mul_prod[PROD_W-1:23];
                default: ;
            endcase
        end

        if (state_reg == ST_TAP)
        begin
            pend_addr_reg   <= tap_addr;
            pend_centre_reg <= (tap_reg == 3'd0);
        end

        if ((state_reg == ST_READ) && out_free)
        begin
            pix_red_reg   <= oor_reg ? '0 : to_byte(rd_reg[0*ACC_W +: ACC_W]);
            pix_green_reg <= oor_reg ? '0 : to_byte(rd_reg[1*ACC_W +: ACC_W]);
            pix_blue_reg  <= oor_reg ? '0 : to_byte(rd_reg[2*ACC_W +: ACC_W]);
        end
    end

`ifndef SYNTHESIS
    a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("tap write and read hit the same pixel");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP) |-> (tap_reg <= TAP_LAST))
        else $error("tap counter out of range");

    a_pix_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid_reg) |-> ($past(state_reg) == ST_READ))
        else $error("pixel item without a read");

    a_splat_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.operation == OP_SPLAT))
        |=> ((state_reg == ST_MUL) && (mstep_reg == 4'd0)))
        else $error("splat did not start the multiply sequence");
`endif

endmodule
